FILE: design/su2r_pkg.sv
// Shared constants and types for the SU(2) rotation update core.
package su2r_pkg;

  localparam int FRAC_BITS_DEF = 16;   // fraction bits of the rotation coefficients
  localparam int DATA_W        = 18;   // link and result entries, signed
  localparam int UNI_W         = 16;   // uniform fractions, Q0.16
  localparam int STEP_W        = 17;   // step_size register
  localparam int STEP_RESET    = 16384;
  localparam int ONE_Q16       = 65536;
  localparam int MAG_W         = 17;   // |2u-1| in Q1.16, up to 1.0
  localparam int SQ_W          = 33;   // one squared component
  localparam int B_W           = 34;   // sum of three squares
  localparam int S_W           = 31;   // sqrt(b * 2^28)
  localparam int S_SHIFT       = 28;
  localparam int N_SHIFT       = 14;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;

  // Data that rides alongside the sqrt and divide pipelines.
  typedef struct packed {
    logic [2:0]              sgn;   // direction component is negative
    logic                    zero;  // direction vector is zero
    logic [7:0][DATA_W-1:0]  r;     // link matrix, row-major, re then im
  } side_t;

endpackage

FILE: design/su2r_delay.sv
// Enabled shift-register delay line.
module su2r_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

FILE: design/su2r_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module su2r_isqrt #(
  parameter int RES_W = 8
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RES_W-1:0] rad_i,
  output logic [RES_W-1:0]   root_o
);

  localparam int W = 2 * RES_W + 1;

  logic [W-1:0]     rem_q  [RES_W];
  logic [RES_W-1:0] root_q [RES_W];

  for (genvar g = 0; g < RES_W; g++) begin : g_stage
    localparam int B = RES_W - 1 - g;
    logic [W-1:0]     rem_in;
    logic [RES_W-1:0] root_in;
    logic [W-1:0]     trial;

    if (g == 0) begin : g_first
      assign rem_in  = {1'b0, rad_i};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // rem >= 2*root*2^B + 2^(2B) means bit B of the root can be set
    assign trial = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[g]  <= rem_in - trial;
          root_q[g] <= root_in | (RES_W'(1) << B);
        end else begin
          rem_q[g]  <= rem_in;
          root_q[g] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RES_W-1];

endmodule

FILE: design/su2r_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Assumes num < den * 2^Q_W.
module su2r_div #(
  parameter int DEN_W = 8,
  parameter int Q_W   = 8
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [Q_W-1:0]         quo_o
);

  localparam int W = DEN_W + Q_W;

  logic [W-1:0]     rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    localparam int B = Q_W - 1 - g;
    logic [W-1:0]     rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [W-1:0]     trial;

    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    assign trial = W'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g] <= den_in;
        if (rem_in >= trial) begin
          rem_q[g] <= rem_in - trial;
          quo_q[g] <= quo_in | (Q_W'(1) << B);
        end else begin
          rem_q[g] <= rem_in;
          quo_q[g] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

FILE: design/su2_random_rotation_update_core.sv
// SU(2) link proposal: C = R * A, A a random near-identity rotation.
// Throughput: one transfer per cycle while the pipe is not stalled; every stage is fully
// pipelined. The latency is set by the bit-per-stage sqrt of |x| (31 stages) and
// dividers (FRAC_BITS stages).
// The whole pipe stalls together when the output holds a result that is not taken.
// Reset: all stage valid bits clear, step_size returns to 0.25 (16384).
module su2_random_rotation_update_core
  import su2r_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [STEP_W-1:0]        cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [UNI_W-1:0]         uniform_eps_i,
  input  logic [UNI_W-1:0]         uniform_x_i,
  input  logic [UNI_W-1:0]         uniform_y_i,
  input  logic [UNI_W-1:0]         uniform_z_i,
  input  logic signed [DATA_W-1:0] r00_re_i,
  input  logic signed [DATA_W-1:0] r00_im_i,
  input  logic signed [DATA_W-1:0] r01_re_i,
  input  logic signed [DATA_W-1:0] r01_im_i,
  input  logic signed [DATA_W-1:0] r10_re_i,
  input  logic signed [DATA_W-1:0] r10_im_i,
  input  logic signed [DATA_W-1:0] r11_re_i,
  input  logic signed [DATA_W-1:0] r11_im_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] c00_re_o,
  output logic signed [DATA_W-1:0] c00_im_o,
  output logic signed [DATA_W-1:0] c01_re_o,
  output logic signed [DATA_W-1:0] c01_im_o,
  output logic signed [DATA_W-1:0] c10_re_o,
  output logic signed [DATA_W-1:0] c10_im_o,
  output logic signed [DATA_W-1:0] c11_re_o,
  output logic signed [DATA_W-1:0] c11_im_o,
  output logic                     zero_direction_o
);

  localparam int F     = FRAC_BITS;
  localparam int A0_W  = F + 1;          // a0 up to 2^F
  localparam int AW    = F + 2;          // signed rotation coefficient
  localparam int N_W   = F + MAG_W + N_SHIFT;  // divider numerator
  localparam int PW    = DATA_W + AW;    // one product
  localparam int SW    = PW + 2;         // sum of four products
  localparam int LAT   = F + 36;
  localparam int SIDE_W = $bits(side_t);
  localparam int A0_DLY = S_W - 1;       // a0 sqrt is F+1 deep, s path is S_W+F deep

  localparam logic signed [SW-1:0] SAT_MAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(OUT_MIN);

  // ---------------------------------------------------------------
  // Control: one valid bit per stage, global stall from the output
  // ---------------------------------------------------------------
  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [STEP_W-1:0] step_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_W'(STEP_RESET);
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: eps product, direction components and their squares
  // ---------------------------------------------------------------
  logic [STEP_W-1:0]        step_clamp;
  logic [UNI_W-1:0]         uni [3];
  logic signed [DATA_W-1:0] dir [3];
  logic [MAG_W-1:0]         mag [3];

  logic [31:0]               eps32_q;
  logic [MAG_W-1:0]          mag_q [3];
  logic [2:0]                sgn_q;
  logic [SQ_W-1:0]           sq_q  [3];
  logic [7:0][DATA_W-1:0]    r0_q;

  assign step_clamp = (step_q > STEP_W'(ONE_Q16)) ? STEP_W'(ONE_Q16) : step_q;
  assign uni[0] = uniform_x_i;
  assign uni[1] = uniform_y_i;
  assign uni[2] = uniform_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = $signed({1'b0, uni[i], 1'b0}) - $signed(DATA_W'(ONE_Q16));
      mag[i] = dir[i][DATA_W-1] ? MAG_W'(-dir[i]) : MAG_W'(dir[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eps32_q <= 32'(uniform_eps_i) * 32'(step_clamp);
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= mag[i];
        sgn_q[i] <= dir[i][DATA_W-1];
        sq_q[i]  <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
      end
      r0_q <= {r11_im_i, r11_re_i, r10_im_i, r10_re_i,
               r01_im_i, r01_re_i, r00_im_i, r00_re_i};
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: epsF, radicand of a0, |x|^2, divider numerators
  // ---------------------------------------------------------------
  logic [F-1:0]    eps_f;
  logic [2*F:0]    rad_a_q;
  logic [B_W-1:0]  b_q;
  logic [N_W-1:0]  num_q [3];
  side_t           side1_q;

  assign eps_f = eps32_q[31 -: F];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_a_q <= ((2*F+1)'(1) << (2*F)) - (2*F+1)'(eps_f) * (2*F+1)'(eps_f);
      b_q     <= B_W'(sq_q[0]) + B_W'(sq_q[1]) + B_W'(sq_q[2]);
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (N_W'(eps_f) * N_W'(mag_q[i])) << N_SHIFT;
      end
      side1_q.sgn  <= sgn_q;
      side1_q.zero <= (sq_q[0] == '0) && (sq_q[1] == '0) && (sq_q[2] == '0);
      side1_q.r    <= r0_q;
    end
  end

  // ---------------------------------------------------------------
  // Square roots, dividers and matching delays
  // ---------------------------------------------------------------
  logic [S_W-1:0]    s_root;
  logic [A0_W-1:0]   a0_root;
  logic [A0_W-1:0]   a0_d;
  logic [3*N_W-1:0]  num_d;
  logic [F-1:0]      quo [3];
  logic [SIDE_W-1:0] side_bits;
  side_t             side_d;

  su2r_isqrt #(.RES_W(S_W)) u_sqrt_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({b_q, S_SHIFT'(0)}),
    .root_o (s_root)
  );

  su2r_isqrt #(.RES_W(A0_W)) u_sqrt_diag (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({1'b0, rad_a_q}),
    .root_o (a0_root)
  );

  su2r_delay #(.WIDTH(A0_W), .DEPTH(A0_DLY)) u_dly_a0 (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (a0_root),
    .q_o   (a0_d)
  );

  su2r_delay #(.WIDTH(3*N_W), .DEPTH(S_W)) u_dly_num (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({num_q[2], num_q[1], num_q[0]}),
    .q_o   (num_d)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    su2r_div #(.DEN_W(S_W), .Q_W(F)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_d[g*N_W +: N_W]),
      .den_i (s_root),
      .quo_o (quo[g])
    );
  end

  su2r_delay #(.WIDTH(SIDE_W), .DEPTH(S_W + F)) u_dly_side (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side1_q),
    .q_o   (side_bits)
  );

  assign side_d = side_t'(side_bits);

  // ---------------------------------------------------------------
  // Rotation matrix A and the 32 partial products
  // ---------------------------------------------------------------
  logic signed [AW-1:0]     coef [3];
  logic signed [AW-1:0]     ar   [2][2];
  logic signed [AW-1:0]     ai   [2][2];
  logic signed [DATA_W-1:0] rre  [2][2];
  logic signed [DATA_W-1:0] rim  [2][2];
  logic signed [PW-1:0]     prod_q [2][2][2][4];
  logic                     zero_p_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // a zero direction gives s = 0; the divider output is then junk
      if (side_d.zero) begin
        coef[i] = '0;
      end else if (side_d.sgn[i]) begin
        coef[i] = -$signed({2'b00, quo[i]});
      end else begin
        coef[i] = $signed({2'b00, quo[i]});
      end
    end
    ar[0][0] = $signed({1'b0, a0_d});
    ar[0][1] = -coef[1];
    ar[1][0] = coef[1];
    ar[1][1] = $signed({1'b0, a0_d});
    ai[0][0] = coef[0];
    ai[0][1] = coef[2];
    ai[1][0] = coef[2];
    ai[1][1] = -coef[0];
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 2; k++) begin
        rre[i][k] = $signed(side_d.r[i*4 + k*2]);
        rim[i][k] = $signed(side_d.r[i*4 + k*2 + 1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_p_q <= side_d.zero;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          for (int k = 0; k < 2; k++) begin
            prod_q[i][j][k][0] <= rre[i][k] * ar[k][j];
            prod_q[i][j][k][1] <= rim[i][k] * ai[k][j];
            prod_q[i][j][k][2] <= rre[i][k] * ai[k][j];
            prod_q[i][j][k][3] <= rim[i][k] * ar[k][j];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Sums of products, exact
  // ---------------------------------------------------------------
  logic signed [SW-1:0] sum_q [8];
  logic                 zero_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_s_q <= zero_p_q;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          sum_q[i*4 + j*2] <= SW'(prod_q[i][j][0][0]) + SW'(prod_q[i][j][1][0])
                            - SW'(prod_q[i][j][0][1]) - SW'(prod_q[i][j][1][1]);
          sum_q[i*4 + j*2 + 1] <= SW'(prod_q[i][j][0][2]) + SW'(prod_q[i][j][1][2])
                                + SW'(prod_q[i][j][0][3]) + SW'(prod_q[i][j][1][3]);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Round half up, saturate, output register
  // ---------------------------------------------------------------
  logic signed [SW-1:0]     rnd [8];
  logic signed [DATA_W-1:0] c_q [8];
  logic                     zero_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rnd[i] = (sum_q[i] + (SW'(1) <<< (F - 1))) >>> F;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= zero_s_q;
      for (int i = 0; i < 8; i++) begin
        if (rnd[i] > SAT_MAX) begin
          c_q[i] <= SAT_MAX[DATA_W-1:0];
        end else if (rnd[i] < SAT_MIN) begin
          c_q[i] <= SAT_MIN[DATA_W-1:0];
        end else begin
          c_q[i] <= rnd[i][DATA_W-1:0];
        end
      end
    end
  end

  assign c00_re_o         = c_q[0];
  assign c00_im_o         = c_q[1];
  assign c01_re_o         = c_q[2];
  assign c01_im_o         = c_q[3];
  assign c10_re_o         = c_q[4];
  assign c10_im_o         = c_q[5];
  assign c11_re_o         = c_q[6];
  assign c11_im_o         = c_q[7];
  assign zero_direction_o = zero_q;

endmodule

FILE: dv/testbench.sv
// Testbench for the SU(2) rotation update core: scoreboard-checked random and directed proposals.
`timescale 1ns / 1ps

module testbench;
  import su2r_pkg::*;

  localparam int LATENCY   = FRAC_BITS_DEF + 36;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 600;

  typedef logic signed [DATA_W-1:0] entry_t;

  // One proposal: four uniforms plus the link matrix, row-major, re then im.
  typedef struct {
    logic [UNI_W-1:0] u_eps, u_x, u_y, u_z;
    entry_t           r [8];
  } proposal_t;

  // One rotated link: eight entries plus the zero-direction flag.
  typedef struct {
    entry_t c [8];
    logic   zero;
  } rotated_t;

  // Scoreboard: holds the rotated links still owed by the core.
  class rotation_board;
    rotated_t   owed [$];
    logic [STEP_W-1:0] step;
    int         mismatches;

    function new();
      step       = STEP_W'(STEP_RESET);
      mismatches = 0;
    endfunction

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v   -= res + bit_v;
          res  = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    // Shift by FRAC_BITS with round-half-up, then clamp to 18 bits.
    function automatic entry_t round_clamp(longint v);
      longint r;
      r = (v + (64'sd1 << (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return entry_t'(r);
    endfunction

    // Compute C = R * A for an accepted proposal and queue it.
    function void note_proposal(proposal_t p);
      longint unsigned st, eps_f, b, s, mag;
      longint d [3];
      longint cf [3];
      longint ar [2][2];
      longint ai [2][2];
      longint a0, re, im, q, rre, rim;
      logic [UNI_W-1:0] u [3];
      rotated_t res;
      st    = (step > ONE_Q16) ? ONE_Q16 : step;
      eps_f = (longint'(p.u_eps) * st) >> (32 - FRAC_BITS_DEF);
      a0    = floor_sqrt((64'd1 << (2 * FRAC_BITS_DEF)) - eps_f * eps_f);
      u[0] = p.u_x; u[1] = p.u_y; u[2] = p.u_z;
      b = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 2 * longint'(u[i]) - ONE_Q16;
        b   += d[i] * d[i];
      end
      res.zero = (b == 0);
      s = floor_sqrt(b << S_SHIFT);
      for (int i = 0; i < 3; i++) begin
        if (res.zero || s == 0) begin
          cf[i] = 0;
        end else begin
          mag   = (d[i] < 0) ? -d[i] : d[i];
          q     = ((eps_f * mag) << N_SHIFT) / s;
          cf[i] = (d[i] < 0) ? -q : q;
        end
      end
      ar[0][0] = a0;     ai[0][0] = cf[0];
      ar[0][1] = -cf[1]; ai[0][1] = cf[2];
      ar[1][0] = cf[1];  ai[1][0] = cf[2];
      ar[1][1] = a0;     ai[1][1] = -cf[0];
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          re = 0;
          im = 0;
          for (int k = 0; k < 2; k++) begin
            rre = p.r[i*4 + k*2];
            rim = p.r[i*4 + k*2 + 1];
            re += rre * ar[k][j] - rim * ai[k][j];
            im += rre * ai[k][j] + rim * ar[k][j];
          end
          res.c[i*4 + j*2]     = round_clamp(re);
          res.c[i*4 + j*2 + 1] = round_clamp(im);
        end
      owed.push_back(res);
    endfunction

    // Compare one transferred result against the oldest owed one.
    function void check_rotated(rotated_t got);
      rotated_t want;
      bit bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
        return;
      end
      want = owed.pop_front();
      bad  = (got.zero !== want.zero);
      for (int i = 0; i < 8; i++) if (got.c[i] !== want.c[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: zero exp %0b got %0b", want.zero, got.zero);
          for (int i = 0; i < 8; i++)
            $display("  entry %0d exp %0d got %0d", i, want.c[i], got.c[i]);
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #2 clk_i = ~clk_i;

  logic              cfg_we_i = 0;
  logic [STEP_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 0;
  logic              in_ready_o;
  logic [UNI_W-1:0]  u_eps_i = '0, u_x_i = '0, u_y_i = '0, u_z_i = '0;
  entry_t            r_i [8];
  logic              out_valid_o;
  logic              out_ready_i = 0;
  entry_t            c_o [8];
  logic              zero_direction_o;

  initial for (int i = 0; i < 8; i++) r_i[i] = '0;

  su2_random_rotation_update_core dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .uniform_eps_i(u_eps_i), .uniform_x_i(u_x_i),
    .uniform_y_i(u_y_i), .uniform_z_i(u_z_i),
    .r00_re_i(r_i[0]), .r00_im_i(r_i[1]), .r01_re_i(r_i[2]), .r01_im_i(r_i[3]),
    .r10_re_i(r_i[4]), .r10_im_i(r_i[5]), .r11_re_i(r_i[6]), .r11_im_i(r_i[7]),
    .out_valid_o, .out_ready_i,
    .c00_re_o(c_o[0]), .c00_im_o(c_o[1]), .c01_re_o(c_o[2]), .c01_im_o(c_o[3]),
    .c10_re_o(c_o[4]), .c10_im_o(c_o[5]), .c11_re_o(c_o[6]), .c11_im_o(c_o[7]),
    .zero_direction_o
  );

  rotation_board board = new();
  bit calm;       // when set, neither side idles
  int cycles = 0;

  // Cycle cap: a hung core ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, results checked on every transfer.
  always @(posedge clk_i) begin
    rotated_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.c    = c_o;
      got.zero = zero_direction_o;
      board.check_rotated(got);
    end
    out_ready_i <= calm || ($urandom_range(99) >= 19);
  end

  // Drive one proposal; valid holds until the transfer and stays up for a
  // back-to-back follower, the idle cycles drop it.
  task automatic send_proposal(proposal_t p);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    u_eps_i <= p.u_eps; u_x_i <= p.u_x; u_y_i <= p.u_y; u_z_i <= p.u_z;
    for (int i = 0; i < 8; i++) r_i[i] <= p.r[i];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_proposal(p);
  endtask

  // Wait for every owed result, then let the pipe drain fully.
  task automatic drain();
    in_valid_i <= 0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Register write between phases only, with the pipe empty.
  task automatic write_step(logic [STEP_W-1:0] v);
    drain();
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 0;
    board.step = v;
  endtask

  function automatic proposal_t rand_proposal();
    proposal_t p;
    p.u_eps = UNI_W'($urandom); p.u_x = UNI_W'($urandom);
    p.u_y = UNI_W'($urandom); p.u_z = UNI_W'($urandom);
    // Mix in near-center directions so the norm gets small.
    if ($urandom_range(9) == 0) begin
      p.u_x = UNI_W'(16'h8000 + $urandom_range(2) - 1);
      p.u_y = UNI_W'(16'h8000 + $urandom_range(2) - 1);
      p.u_z = UNI_W'(16'h8000 + $urandom_range(2) - 1);
    end
    for (int i = 0; i < 8; i++)
      p.r[i] = ($urandom_range(3) == 0) ? entry_t'($urandom) :
               entry_t'($signed($urandom_range(131072)) - 65536);
    return p;
  endfunction

  function automatic proposal_t fixed_proposal(logic [UNI_W-1:0] e, x, y, z,
                                               entry_t rv);
    proposal_t p;
    p.u_eps = e; p.u_x = x; p.u_y = y; p.u_z = z;
    for (int i = 0; i < 8; i++) p.r[i] = (i[0]) ? -rv : rv;
    return p;
  endfunction

  initial begin
    logic [STEP_W-1:0] steps [4];
    proposal_t p;
    calm = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes, zero direction, saturation.
    send_proposal(fixed_proposal(16'h0000, 16'h8000, 16'h8000, 16'h8000, 18'sd65536));
    send_proposal(fixed_proposal(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 18'sd65536));
    send_proposal(fixed_proposal(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 18'sd131071));
    send_proposal(fixed_proposal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -18'sd131072));
    send_proposal(fixed_proposal(16'h8000, 16'hFFFF, 16'h0000, 16'h8000, 18'sd131071));
    send_proposal(fixed_proposal(16'h1234, 16'h8001, 16'h8000, 16'h8000, -18'sd1));
    send_proposal(fixed_proposal(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 18'sd0));
    write_step(17'd65536);
    send_proposal(fixed_proposal(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 18'sd131071));
    send_proposal(fixed_proposal(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, -18'sd131072));
    // Step beyond one is clamped to one.
    write_step(17'h1FFFF);
    send_proposal(fixed_proposal(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 18'sd131071));
    write_step(17'd0);
    send_proposal(fixed_proposal(16'hFFFF, 16'h0001, 16'h7FFF, 16'hFFFF, 18'sd100000));

    // Random phases across several step settings; the last phase runs without idling.
    steps[0] = STEP_W'($urandom_range(65536)); steps[1] = 17'd65536;
    steps[2] = 17'd1; steps[3] = STEP_W'(STEP_RESET);
    for (int ph = 0; ph < 4; ph++) begin
      write_step(steps[ph]);
      calm = (ph == 3);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        p = rand_proposal();
        send_proposal(p);
        // Sender holds off until the core is fully drained.
        if (ph == 1 && n == 50) begin
          in_valid_i <= 0;
          while (board.owed.size() != 0) @(posedge clk_i);
        end
      end
    end
    calm = 0;
    drain();

    if (board.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/su2r_pkg.sv
design/su2r_delay.sv
design/su2r_isqrt.sv
design/su2r_div.sv
design/su2_random_rotation_update_core.sv
dv/testbench.sv
